[hdl/byte_ring_fifo_packet_admit_top_assert.svh]
// ----------------------------------------------------------------------------
// byte_ring_fifo_packet_admit_top_assert
// Assertion macros shared by the byte ring FIFO block.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_PACKET_ADMIT_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_PACKET_ADMIT_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BRFPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BRFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/brfpa_pkg.sv]
// ----------------------------------------------------------------------------
// brfpa_pkg
// Types and constants of the byte ring FIFO with packet admission.
// ----------------------------------------------------------------------------
package brfpa_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 11;
  localparam int FILL_W = 11;
  localparam int CL_W   = 4;
  localparam int ADDR_W = 3;

  localparam logic [CL_W-1:0] CAP_LOG2_RESET = 4'd10;
  localparam logic            REG_CAP_LOG2   = 1'b0;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_PACKET = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SEQ   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DATA_W-1:0] data_byte;
    logic             packet_first;
    logic [LEN_W-1:0] packet_length;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_data;
    logic [FILL_W-1:0] fill_level;
    logic [FILL_W-1:0] capacity;
    logic              packet_open;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
    logic load_rem;
    logic dec_rem;
    logic reserve;
  } dp_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic write_room;
    logic pkt_fits;
    logic rem_is_one;
    logic len_is_zero;
    logic len_is_one;
  } dp_stat_t;

endpackage

[hdl/byte_ring_fifo_packet_admit_top.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_packet_admit_top
// Byte FIFO over a power-of-two ring with all-or-nothing packet admission.
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+---------------
//   command  | start && !busy                   | cmd_i
//   result   | result_valid_o, one cycle        | result_o
//   config   | psel && penable && pwrite        | paddr, pwdata
//
// One command per cycle: busy stays low and the result strobes in the cycle
// after acceptance.
// Reset empties the FIFO and closes any packet; storage is not cleared.
// The result receiver cannot stall, and nothing waits on it.
// ----------------------------------------------------------------------------
module byte_ring_fifo_packet_admit_top #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  brfpa_pkg::cmd_t              cmd_i,
  output logic                         result_valid_o,
  output brfpa_pkg::result_t           result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brfpa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import brfpa_pkg::*;

  `include "byte_ring_fifo_packet_admit_top_assert.svh"

  localparam int CW = $clog2(MAX_DEPTH + 1);

  logic              accept, clear, rd_ok, pkt_open;
  logic [CL_W-1:0]   cap_log2;
  logic [1:0]        status;
  logic [DATA_W-1:0] rd_data;
  logic [CW-1:0]     count, cap;
  dp_ctl_t           ctl;
  dp_stat_t          stat;
  logic              empty_beat, empty_clean;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  brfpa_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cap_log2_o (cap_log2),
    .clear_o    (clear)
  );

  brfpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .clear_i  (clear),
    .kind_i   (cmd_i.kind),
    .first_i  (cmd_i.packet_first),
    .stat_i   (stat),
    .ctl_o    (ctl),
    .valid_o  (result_valid_o),
    .status_o (status),
    .rd_ok_o  (rd_ok),
    .open_o   (pkt_open)
  );

  brfpa_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .cap_log2_i (cap_log2),
    .data_i     (cmd_i.data_byte),
    .len_i      (cmd_i.packet_length),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .rd_data_o  (rd_data),
    .count_o    (count),
    .cap_o      (cap)
  );

  // Counts already hold the post-step values while the result is shown.
  assign result_o.status      = status;
  assign result_o.read_data   = rd_ok ? rd_data : '0;
  assign result_o.fill_level  = FILL_W'(count);
  assign result_o.capacity    = FILL_W'(cap);
  assign result_o.packet_open = pkt_open;

  assign empty_beat  = result_valid_o && (status == ST_EMPTY);
  assign empty_clean = (count == '0) && (result_o.read_data == '0);

  `BRFPA_ASSERT_NEXT(a_strobe_follows_accept, clk_i, rst_ni, accept, result_valid_o)
  `BRFPA_ASSERT_NEXT(a_no_strobe_unasked, clk_i, rst_ni, !accept, !result_valid_o)
  `BRFPA_ASSERT_NOW(a_fill_within_cap, clk_i, rst_ni, 1'b1, count <= cap)
  `BRFPA_ASSERT_NOW(a_empty_means_zero, clk_i, rst_ni, empty_beat, empty_clean)

endmodule

[hdl/brfpa_regs.sv]
// ----------------------------------------------------------------------------
// brfpa_regs
// APB register file holding capacity_log2; a write also empties the FIFO.
// ----------------------------------------------------------------------------
module brfpa_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brfpa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [brfpa_pkg::CL_W-1:0]  cap_log2_o,
  output logic                        clear_o
);
  import brfpa_pkg::*;

  logic [CL_W-1:0] cap_log2_q, cap_log2_d;
  logic            hit;

  assign pready  = 1'b1;
  assign hit     = (paddr[2] == REG_CAP_LOG2);
  assign clear_o = psel && penable && pwrite && pready && hit;

  always_comb begin
    cap_log2_d = cap_log2_q;
    if (clear_o) begin
      cap_log2_d = pwdata[CL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= CAP_LOG2_RESET;
    end else begin
      cap_log2_q <= cap_log2_d;
    end
  end

  assign prdata     = hit ? {{(32-CL_W){1'b0}}, cap_log2_q} : 32'd0;
  assign cap_log2_o = cap_log2_q;

endmodule

[hdl/brfpa_ctrl.sv]
// ----------------------------------------------------------------------------
// brfpa_ctrl
// Packet state machine and operation decode; issues datapath commands and
// registers the result status and strobe.
// ----------------------------------------------------------------------------
module brfpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 clear_i,
  input  logic [1:0]           kind_i,
  input  logic                 first_i,
  input  brfpa_pkg::dp_stat_t  stat_i,
  output brfpa_pkg::dp_ctl_t   ctl_o,
  output logic                 valid_o,
  output logic [1:0]           status_o,
  output logic                 rd_ok_o,
  output logic                 open_o
);
  import brfpa_pkg::*;

  typedef enum logic [1:0] {
    PKT_NONE,
    PKT_ADMIT,
    PKT_DROP
  } pkt_state_e;

  pkt_state_e state_q, state_d;
  logic [1:0] status_q, status_d;
  logic       valid_q, rd_ok_q, rd_ok_d;

  always_comb begin
    state_d  = state_q;
    status_d = ST_OK;
    rd_ok_d  = 1'b0;
    ctl_o    = '0;
    // Space held by an admitted packet is off limits to plain writes.
    ctl_o.reserve = (state_q == PKT_ADMIT);
    if (accept_i) begin
      case (kind_i)
        KIND_WRITE: begin
          if (stat_i.write_room) ctl_o.push = 1'b1;
          else status_d = ST_FULL;
        end
        KIND_READ: begin
          if (stat_i.empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctl_o.pop = 1'b1;
            rd_ok_d   = 1'b1;
          end
        end
        KIND_FLUSH: ctl_o.flush = 1'b1;
        KIND_PACKET: begin
          if (first_i) begin
            if (state_q != PKT_NONE) begin
              status_d = ST_SEQ;
            end else if (stat_i.len_is_zero) begin
              status_d = ST_FULL;
            end else if (!stat_i.pkt_fits) begin
              status_d       = ST_FULL;
              ctl_o.load_rem = 1'b1;
              if (!stat_i.len_is_one) state_d = PKT_DROP;
            end else begin
              ctl_o.push     = 1'b1;
              ctl_o.load_rem = 1'b1;
              if (!stat_i.len_is_one) state_d = PKT_ADMIT;
            end
          end else begin
            case (state_q)
              PKT_ADMIT: begin
                ctl_o.push    = 1'b1;
                ctl_o.dec_rem = 1'b1;
                if (stat_i.rem_is_one) state_d = PKT_NONE;
              end
              PKT_DROP: begin
                status_d      = ST_FULL;
                ctl_o.dec_rem = 1'b1;
                if (stat_i.rem_is_one) state_d = PKT_NONE;
              end
              default: status_d = ST_SEQ;
            endcase
          end
        end
        default: status_d = ST_OK;
      endcase
    end
    if (clear_i) state_d = PKT_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= PKT_NONE;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
      rd_ok_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= accept_i;
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign rd_ok_o  = rd_ok_q;
  assign open_o   = (state_q != PKT_NONE);

endmodule

[hdl/brfpa_dp.sv]
// ----------------------------------------------------------------------------
// brfpa_dp
// Ring storage, head and tail pointers, fill count and packet reservation
// counter, with the compares the controller decides on.
// ----------------------------------------------------------------------------
module brfpa_dp #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic [brfpa_pkg::CL_W-1:0]     cap_log2_i,
  input  logic [brfpa_pkg::DATA_W-1:0]   data_i,
  input  logic [brfpa_pkg::LEN_W-1:0]    len_i,
  input  brfpa_pkg::dp_ctl_t             ctl_i,
  output brfpa_pkg::dp_stat_t            stat_o,
  output logic [brfpa_pkg::DATA_W-1:0]   rd_data_o,
  output logic [$clog2(MAX_DEPTH+1)-1:0] count_o,
  output logic [$clog2(MAX_DEPTH+1)-1:0] cap_o
);
  import brfpa_pkg::*;

  localparam int CW  = $clog2(MAX_DEPTH + 1);
  localparam int IW  = CW - 1;   // log2 of the largest usable ring
  localparam int SW  = ((CW > LEN_W) ? CW : LEN_W) + 1;

  logic [DATA_W-1:0] mem [2**IW];
  logic [DATA_W-1:0] rd_q;

  logic [IW-1:0]    head_q, head_d, tail_q, tail_d, mask;
  logic [CW-1:0]    count_q, count_d, cap;
  logic [LEN_W-1:0] rem_q, rem_d, reserved;
  logic [CL_W-1:0]  eff_log2;

  // A configured size beyond the memory falls back to the largest ring.
  assign eff_log2 = (32'(cap_log2_i) > IW) ? CL_W'(IW) : cap_log2_i;
  assign cap      = CW'(1) << eff_log2;
  assign mask     = IW'(cap - CW'(1));
  assign reserved = ctl_i.reserve ? rem_q : '0;

  assign stat_o.empty       = (count_q == '0);
  assign stat_o.write_room  = (SW'(count_q) + SW'(reserved)) < SW'(cap);
  assign stat_o.pkt_fits    = (SW'(count_q) + SW'(len_i)) <= SW'(cap);
  assign stat_o.rem_is_one  = (rem_q == LEN_W'(1));
  assign stat_o.len_is_zero = (len_i == '0);
  assign stat_o.len_is_one  = (len_i == LEN_W'(1));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    rem_d   = rem_q;
    if (ctl_i.push) begin
      head_d  = IW'(head_q + IW'(1)) & mask;
      count_d = count_q + CW'(1);
    end
    if (ctl_i.pop) begin
      tail_d  = IW'(tail_q + IW'(1)) & mask;
      count_d = count_q - CW'(1);
    end
    if (ctl_i.flush) begin
      tail_d  = head_q;
      count_d = '0;
    end
    if (ctl_i.load_rem) rem_d = len_i - LEN_W'(1);
    if (ctl_i.dec_rem)  rem_d = rem_q - LEN_W'(1);
    if (clear_i) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      rem_q   <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem[head_q] <= data_i;
    if (ctl_i.pop)  rd_q <= mem[tail_q];
  end

  assign rd_data_o = rd_q;
  assign count_o   = count_q;
  assign cap_o     = cap;

endmodule

[tb/byte_ring_fifo_packet_admit_top_tb.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_packet_admit_top_tb
// Drives byte writes, reads, flushes and streamed packets into the ring FIFO
// and checks every result beat against a behavioral FIFO kept in a scoreboard.
// The capacity register is rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module byte_ring_fifo_packet_admit_top_tb;
  import brfpa_pkg::*;

  localparam int MAX_DEPTH       = 1024;
  localparam int IDX_W           = $clog2(MAX_DEPTH);
  localparam int PHASE_ITEMS     = 135;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam logic [ADDR_W-1:0] CAP_LOG2_ADDR = ADDR_W'(4 * REG_CAP_LOG2);

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  cmd_t              cmd_i;
  logic              result_valid_o;
  result_t           result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned sender_idle_pct;
  int unsigned quiet_cycles;

  byte_ring_fifo_packet_admit_top #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  class fifo_admit_scoreboard;
    logic [7:0]  ring_mem [MAX_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned stored;
    int unsigned remaining;
    bit          dropping;
    logic [3:0]  cap_log2;
    result_t     due[$];
    int unsigned errors;

    function new();
      cap_log2 = CAP_LOG2_RESET;
      errors   = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      head      = 0;
      tail      = 0;
      stored    = 0;
      remaining = 0;
      dropping  = 1'b0;
    endfunction

    function void set_capacity_log2(logic [3:0] value);
      cap_log2 = value;
      clear_ring();
    endfunction

    // Sizes past MAX_DEPTH fold back to the largest power of two that fits.
    function int unsigned ring_size();
      int unsigned size;
      size = 1 << cap_log2;
      while (size > MAX_DEPTH) size >>= 1;
      return size;
    endfunction

    function void push_byte(logic [7:0] value, int unsigned size);
      ring_mem[IDX_W'(head & (size - 1))] = value;
      head   = (head + 1) & (size - 1);
      stored++;
    endfunction

    function void note_command(cmd_t c);
      int unsigned size;
      int unsigned reserved;
      int unsigned len;
      bit          open;
      result_t     r;
      size      = ring_size();
      len       = 32'(c.packet_length);
      open      = (remaining != 0);
      r         = '0;
      r.status  = ST_OK;
      case (kind_e'(c.kind))
        KIND_WRITE: begin
          // Only an admitted packet holds space; a dropping one does not.
          reserved = (open && !dropping) ? remaining : 0;
          if (stored + reserved >= size) r.status = ST_FULL;
          else push_byte(c.data_byte, size);
        end
        KIND_READ: begin
          if (stored == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.read_data = ring_mem[IDX_W'(tail & (size - 1))];
            tail        = (tail + 1) & (size - 1);
            stored--;
          end
        end
        KIND_FLUSH: begin
          tail   = head;
          stored = 0;
        end
        default: begin
          if (c.packet_first) begin
            if (open) begin
              r.status = ST_SEQ;
            end else if (len == 0) begin
              r.status = ST_FULL;
            end else if (stored + len > size) begin
              r.status  = ST_FULL;
              remaining = len - 1;
              dropping  = (remaining != 0);
            end else begin
              push_byte(c.data_byte, size);
              remaining = len - 1;
              dropping  = 1'b0;
            end
          end else if (!open) begin
            r.status = ST_SEQ;
          end else if (dropping) begin
            r.status = ST_FULL;
            remaining--;
            if (remaining == 0) dropping = 1'b0;
          end else begin
            push_byte(c.data_byte, size);
            remaining--;
          end
        end
      endcase
      r.fill_level  = FILL_W'(stored);
      r.capacity    = FILL_W'(size);
      r.packet_open = (remaining != 0);
      due.push_back(r);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t r);
      result_t exp;
      if (due.size() == 0) begin
        $display("%0t unexpected result beat: status %0d fill_level %0d", $time,
                 r.status, r.fill_level);
        errors++;
        return;
      end
      exp = due.pop_front();
      compare("status", 32'(exp.status), 32'(r.status));
      compare("read_data", 32'(exp.read_data), 32'(r.read_data));
      compare("fill_level", 32'(exp.fill_level), 32'(r.fill_level));
      compare("capacity", 32'(exp.capacity), 32'(r.capacity));
      compare("packet_open", 32'(exp.packet_open), 32'(r.packet_open));
    endfunction
  endclass

  fifo_admit_scoreboard sb;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // Any accepted beat, result or register access counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("byte_ring_fifo_packet_admit_top test failed");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(kind_e k, logic [7:0] d, logic f, logic [10:0] n);
    cmd_t c;
    c.kind          = k;
    c.data_byte     = d;
    c.packet_first  = f;
    c.packet_length = n;
    return c;
  endfunction

  function automatic logic [10:0] pick_length(int unsigned size);
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(99);
    if (roll < 8) return 11'd0;
    if (roll < 10) return 11'($urandom_range(2047, 1));
    top = (roll < 75) ? size + 1 : 2 * size + 2;
    if (top > 2047) top = 2047;
    return 11'($urandom_range(top, 1));
  endfunction

  // Mostly well-formed packet streams interleaved with plain traffic; the rest
  // are broken sequences: orphan bytes and first bytes while a packet is open.
  function automatic cmd_t make_random_command(int unsigned write_pct);
    cmd_t        c;
    int unsigned roll;
    c.data_byte     = 8'($urandom);
    c.packet_first  = 1'($urandom);
    c.packet_length = 11'($urandom);
    roll = $urandom_range(99);
    if (sb.remaining != 0 && roll < 55) begin
      c.kind         = KIND_PACKET;
      c.packet_first = ($urandom_range(19) == 0);
    end else begin
      roll = $urandom_range(99);
      if (roll < 14) begin
        c.kind          = KIND_PACKET;
        c.packet_first  = 1'b1;
        c.packet_length = pick_length(sb.ring_size());
      end else if (roll < 17) begin
        c.kind         = KIND_PACKET;
        c.packet_first = 1'b0;
      end else if (roll < 20) begin
        c.kind = KIND_FLUSH;
      end else if (roll < 20 + write_pct) begin
        c.kind = KIND_WRITE;
      end else begin
        c.kind = KIND_READ;
      end
    end
    return c;
  endfunction

  task automatic send_command(input cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the capacity register, then read it back.
  task automatic write_capacity_log2(input logic [3:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_LOG2_ADDR;
    pwdata  <= ($urandom & 32'hFFFF_FFF0) | 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_capacity_log2(value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.compare("capacity_log2 readback", 32'(value), 32'(prdata[CL_W-1:0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [3:0]  settings [8];
    int unsigned item_idx;
    start           = 1'b0;
    cmd_i           = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_ni          = 1'b0;
    quiet_cycles    = 0;
    sender_idle_pct = 30;
    sb              = new();
    settings        = '{4'd0, 4'd3, 4'd15, 4'd1, 4'd6, 4'd2, 4'd10, 4'd4};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: empty read, refused huge packet that keeps dropping,
    // and a plain write that a dropping packet does not block.
    send_command(mk_cmd(KIND_READ, 8'h00, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_WRITE, 8'h00, 1'b1, 11'h7FF));
    send_command(mk_cmd(KIND_WRITE, 8'hFF, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'hAA, 1'b1, 11'd2047));
    send_command(mk_cmd(KIND_PACKET, 8'h55, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'h11, 1'b1, 11'd3));
    send_command(mk_cmd(KIND_WRITE, 8'h80, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_READ, 8'h00, 1'b1, 11'd5));
    drain_results();

    // Capacity two: the rewrite also closes the dropping packet.
    write_capacity_log2(4'd1);
    send_command(mk_cmd(KIND_PACKET, 8'h21, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'h22, 1'b1, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'h23, 1'b1, 11'd2));
    send_command(mk_cmd(KIND_WRITE, 8'h24, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_FLUSH, 8'h00, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'h25, 1'b1, 11'd1));
    send_command(mk_cmd(KIND_PACKET, 8'h26, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'h27, 1'b1, 11'd3));
    send_command(mk_cmd(KIND_PACKET, 8'h28, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'h29, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_READ, 8'h00, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_WRITE, 8'h31, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_WRITE, 8'h32, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_WRITE, 8'h33, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_FLUSH, 8'h00, 1'b1, 11'd9));
    drain_results();

    // Oversized setting saturates; a full-size packet fits an empty ring.
    write_capacity_log2(4'd15);
    send_command(mk_cmd(KIND_PACKET, 8'h3C, 1'b1, 11'd1));
    send_command(mk_cmd(KIND_READ, 8'h00, 1'b0, 11'd0));
    send_command(mk_cmd(KIND_PACKET, 8'hC3, 1'b1, 11'd1024));
    send_command(mk_cmd(KIND_WRITE, 8'h7E, 1'b0, 11'd0));
    drain_results();

    item_idx = 0;
    foreach (settings[p]) begin
      write_capacity_log2(settings[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (item_idx < 360) sender_idle_pct = 30;
        else if (item_idx < 720) sender_idle_pct = 88;
        else sender_idle_pct = 0;
        send_command(make_random_command((i < PHASE_ITEMS / 2) ? 55 : 25));
        item_idx++;
      end
      drain_results();
    end

    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("byte_ring_fifo_packet_admit_top test passed");
    end else begin
      $display("byte_ring_fifo_packet_admit_top test failed");
    end
    $finish;
  end

endmodule
